// ===== rtl/pdrc_pkg.sv =====
// Shared types, constants and codes for the PWM duty ramp controller.
package pdrc_pkg;

	localparam int DUTY_W = 15;
	localparam int TIME_W = 32;
	localparam int CHAN_W = 3;
	localparam int RES_W = 5;
	localparam int CHANNELS_DEF = 8;

	// Full scale duty, 100% in Q7.8 percent.
	localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd25600;

	// Item operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Quotient bits produced by the serial divider for each division.
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] COUNT_DIV_ITERS = 6'd15;
	localparam logic [DIV_CNT_W-1:0] DELAY_DIV_ITERS = 6'd32;

	typedef struct packed {
		logic op;
		logic [CHAN_W-1:0] channel;
		logic [RES_W-1:0] pwm_res;
		logic [DUTY_W-1:0] target_duty;
		logic [DUTY_W-1:0] step_duty;
		logic [TIME_W-1:0] total_time_ms;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [RES_W-1:0] out_resolution;
		logic [DUTY_W-1:0] duty;
		logic last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic tick_dec;
		logic count_div_start;
		logic delay_div_start;
		logic delay_one;
		logic delay_div;
		logic advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic start_ok;
		logic ramping;
		logic tick_fire;
		logic div_done;
		logic div_zero;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/pdrc_stream_if.sv =====
// Valid/ready stream interface carrying one payload item per transfer.
interface pdrc_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/pdrc_div.sv =====
// Serial restoring divider, one quotient bit per cycle, 32-bit by 15-bit.
module pdrc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [pdrc_pkg::TIME_W-1:0] dividend,
	input logic [pdrc_pkg::DUTY_W-1:0] divisor,
	input logic [pdrc_pkg::DIV_CNT_W-1:0] iters,
	output logic busy,
	output logic done,
	output logic [pdrc_pkg::TIME_W-1:0] quotient
);
	import pdrc_pkg::*;

	logic [TIME_W-1:0] dq_q;
	logic [DUTY_W-1:0] rem_q;
	logic [DUTY_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DUTY_W:0] trial;
	logic take;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial = {rem_q, dq_q[TIME_W-1]};
	assign take = trial >= {1'b0, dvs_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= iters;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register; the divisor is held for the whole run.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			dq_q <= {dq_q[TIME_W-2:0], take};
			rem_q <= take ? DUTY_W'(trial - {1'b0, dvs_q}) : trial[DUTY_W-1:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quotient = dq_q;
endmodule

// ===== rtl/pdrc_datapath.sv =====
// Ramp state, per-channel duty store, divider and output register.
module pdrc_datapath #(
	parameter int CHANNELS = pdrc_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input pdrc_pkg::in_item_t req_payload,
	input pdrc_pkg::cmd_t cmd,
	output pdrc_pkg::status_t status,
	pdrc_stream_if.source duty_write
);
	import pdrc_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	in_item_t req_q;
	logic [DUTY_W-1:0] channel_duty_q [CHANNELS];
	logic ramping_q;
	logic [DUTY_W-1:0] ramp_value_q;
	logic [DUTY_W-1:0] ramp_target_q;
	logic [DUTY_W-1:0] ramp_step_q;
	logic going_up_q;
	logic [TIME_W-1:0] delay_length_q;
	logic [TIME_W-1:0] ticks_left_q;
	logic [CHAN_W-1:0] active_channel_q;
	logic [RES_W-1:0] active_resolution_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [DUTY_W-1:0] tgt_sat;
	logic [DUTY_W-1:0] cur_duty;
	logic [DUTY_W-1:0] start_dist;
	logic [DUTY_W-1:0] ramp_dist;
	logic [DUTY_W:0] up_sum;
	logic [DUTY_W-1:0] up_val;
	logic [DUTY_W-1:0] down_val;
	logic [DUTY_W-1:0] next_val;
	logic more_steps;
	logic div_start;
	logic [TIME_W-1:0] div_dividend;
	logic [DUTY_W-1:0] div_divisor;
	logic [DIV_CNT_W-1:0] div_iters;
	logic div_busy;
	logic div_done;
	logic [TIME_W-1:0] div_quot;

	// Start command operands: saturated target and the channel's last duty.
	assign tgt_sat = (req_q.target_duty > FULL_DUTY) ? FULL_DUTY : req_q.target_duty;
	assign cur_duty = channel_duty_q[IDX_W'(req_q.channel)];
	assign start_dist = (tgt_sat > cur_duty) ? tgt_sat - cur_duty : cur_duty - tgt_sat;

	// Next ramp value: one step toward the target, clamped to 0..100%.
	assign ramp_dist = (ramp_value_q > ramp_target_q) ? ramp_value_q - ramp_target_q
		: ramp_target_q - ramp_value_q;
	assign more_steps = ramp_dist > ramp_step_q;
	assign up_sum = {1'b0, ramp_value_q} + {1'b0, ramp_step_q};
	assign up_val = (up_sum > {1'b0, FULL_DUTY}) ? FULL_DUTY : up_sum[DUTY_W-1:0];
	assign down_val = (ramp_value_q > ramp_step_q) ? ramp_value_q - ramp_step_q : '0;
	assign next_val = more_steps ? (going_up_q ? up_val : down_val) : ramp_target_q;

	// Divider operand selection: step count first, then delay per step.
	assign div_start = cmd.count_div_start || cmd.delay_div_start;
	always_comb begin
		if (cmd.count_div_start) begin
			div_dividend = {start_dist, (TIME_W-DUTY_W)'(0)};
			div_divisor = req_q.step_duty;
			div_iters = COUNT_DIV_ITERS;
		end else begin
			div_dividend = req_q.total_time_ms;
			div_divisor = div_quot[DUTY_W-1:0];
			div_iters = DELAY_DIV_ITERS;
		end
	end

	pdrc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.iters(div_iters),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quot)
	);

	// Captured request item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_payload;
		end
	end

	// Ramp state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramping_q <= 1'b0;
			ramp_value_q <= '0;
			ramp_target_q <= '0;
			ramp_step_q <= '0;
			going_up_q <= 1'b0;
			delay_length_q <= TIME_W'(1);
			ticks_left_q <= '0;
			active_channel_q <= '0;
			active_resolution_q <= '0;
		end else begin
			if (cmd.setup) begin
				active_channel_q <= req_q.channel;
				active_resolution_q <= req_q.pwm_res;
				ramp_value_q <= cur_duty;
				ramp_target_q <= tgt_sat;
				ramp_step_q <= req_q.step_duty;
				going_up_q <= tgt_sat > cur_duty;
			end
			if (cmd.delay_one || (cmd.delay_div && div_quot == '0)) begin
				delay_length_q <= TIME_W'(1);
			end else if (cmd.delay_div) begin
				delay_length_q <= div_quot;
			end
			if (cmd.tick_dec && ticks_left_q != '0) begin
				ticks_left_q <= ticks_left_q - 1'b1;
			end
			if (cmd.advance) begin
				ramp_value_q <= next_val;
				ramping_q <= more_steps;
				ticks_left_q <= more_steps ? delay_length_q : '0;
			end
		end
	end

	// Per-channel store of the last written duty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				channel_duty_q[i] <= '0;
			end
		end else if (cmd.advance) begin
			channel_duty_q[IDX_W'(active_channel_q)] <= next_val;
		end
	end

	// Output register: holds a duty write until the sink takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.advance) begin
			out_valid_q <= 1'b1;
		end else if (duty_write.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			out_q.out_channel <= active_channel_q;
			out_q.out_resolution <= active_resolution_q;
			out_q.duty <= next_val;
			out_q.last <= !more_steps;
		end
	end

	assign duty_write.valid = out_valid_q;
	assign duty_write.payload = out_q;

	// Status toward the controller.
	always_comb begin
		status.is_tick = req_q.op == OP_TICK;
		status.start_ok = (req_q.step_duty != '0) && (req_q.step_duty <= FULL_DUTY)
			&& !ramping_q && (32'(req_q.channel) < CHANNELS);
		status.ramping = ramping_q;
		status.tick_fire = ticks_left_q <= TIME_W'(1);
		status.div_done = div_done;
		status.div_zero = div_quot == '0;
		status.out_free = !out_valid_q || duty_write.ready;
	end

`ifndef SYNTH
	// The delay between steps is never zero.
	a_delay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		delay_length_q != '0)
		else $error("delay length is zero");

	// The ramp value never leaves the 0..100% range.
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_value_q <= FULL_DUTY)
		else $error("ramp value above full duty");

	// A new duty write is only produced into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> (!out_valid_q || duty_write.ready))
		else $error("duty write overwrote a pending result");

	// The divider is never restarted while it is still iterating.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
`endif
endmodule

// ===== rtl/pdrc_ctrl.sv =====
// Controller state machine sequencing decode, division and duty writes.
module pdrc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input pdrc_pkg::status_t status,
	output pdrc_pkg::cmd_t cmd
);
	import pdrc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_COUNT_DIV = 3'd2;
	localparam logic [2:0] ST_DELAY_DIV = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = state_q == ST_IDLE;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.is_tick) begin
					if (!status.ramping) begin
						state_d = ST_IDLE;
					end else begin
						cmd.tick_dec = 1'b1;
						state_d = status.tick_fire ? ST_EMIT : ST_IDLE;
					end
				end else if (status.start_ok) begin
					cmd.setup = 1'b1;
					cmd.count_div_start = 1'b1;
					state_d = ST_COUNT_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT_DIV: begin
				if (status.div_done) begin
					if (status.div_zero) begin
						cmd.delay_one = 1'b1;
						state_d = ST_EMIT;
					end else begin
						cmd.delay_div_start = 1'b1;
						state_d = ST_DELAY_DIV;
					end
				end
			end
			ST_DELAY_DIV: begin
				if (status.div_done) begin
					cmd.delay_div = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.advance = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// Requests are taken only in the idle state.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("request captured outside idle");

	// A duty write always returns the controller to idle.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |=> state_q == ST_IDLE)
		else $error("controller not idle after duty write");

	// Ramp setup always launches the step count division.
	a_setup_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |-> cmd.count_div_start)
		else $error("setup without step count division");
`endif
endmodule

// ===== rtl/pwm_duty_ramp_controller_core.sv =====
// PWM duty ramp controller top level: controller, datapath and stream ports.
//
// Each request transfer is either a ramp start or a one millisecond tick, and
// produces at most one duty write transfer. The block works on one request at
// a time. A tick is captured and decoded before the next request can be taken,
// and also passes the write state when it produces a duty write. A start is
// captured and decoded, then the step count and the per-step delay come from
// one shared serial divider that yields one quotient bit per cycle, and then
// the duty is written. When the count is zero the second division is skipped.
// A dropped start is only captured and decoded.
// A finished duty write waits in an output register, so the next request is
// taken while it is still pending; a later write waits until it is free.
// Starts with a zero step, a step above 100%, a channel out of range or a ramp
// already running are dropped without a write.
module pwm_duty_ramp_controller_core #(
	parameter int CHANNELS = pdrc_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	pdrc_stream_if.sink request,
	pdrc_stream_if.source duty_write
);
	import pdrc_pkg::*;

	cmd_t cmd;
	status_t status;
	logic req_ready;

	assign request.ready = req_ready;

	// Sequencing of each request.
	pdrc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(request.valid),
		.req_ready(req_ready),
		.status(status),
		.cmd(cmd)
	);

	// Ramp state, channel store, divider and output register.
	pdrc_datapath #(
		.CHANNELS(CHANNELS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req_payload(request.payload),
		.cmd(cmd),
		.status(status),
		.duty_write(duty_write)
	);
endmodule
